// ===== rtl/core/srma_pkg.sv =====
// Package for the serial register access master: beat types, mode codes,
// register indexes and phase codes. No dependencies.
package srma_pkg;

  localparam int BYTE_BITS = 8;
  localparam int HALF_BITS = 2 * BYTE_BITS;
  localparam int CNT_W     = 5;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_WRITE  = 3'd2;
  localparam logic [2:0] MODE_MWRITE = 3'd3;
  localparam logic [2:0] MODE_FREAD  = 3'd4;

  localparam logic CFG_READ_OP  = 1'b0;
  localparam logic CFG_WRITE_OP = 1'b1;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_F1_OP   = 3'd1;
  localparam logic [2:0] PH_F1_DATA = 3'd2;
  localparam logic [2:0] PH_GAP     = 3'd3;
  localparam logic [2:0] PH_F2_OP   = 3'd4;
  localparam logic [2:0] PH_F2_DATA = 3'd5;

  localparam logic [7:0] MSB_MASK  = 8'h80;
  localparam logic [4:0] ADDR_MASK = 5'h1f;

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] reg_addr;
    logic [2:0] bit_shift;
    logic [7:0] field_mask;
    logic [7:0] write_value;
    logic       miso;
  } req_t;

  typedef struct packed {
    logic       select;
    logic       clock_pin;
    logic       mosi;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

  typedef struct packed {
    logic request;
    req_t item;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_link_t;

endpackage

// ===== rtl/core/serial_register_access_master_unit.sv =====
// Top level of the serial register access master: front queue and frame sequencer.
// Depends on srma_pkg, srma_front and srma_back.
//
//   channel   handshake           payload
//   request   push / full         req (srma_pkg::req_t)
//   result    empty / pop         res (srma_pkg::res_t)
//   config    cfg_we              cfg_index, cfg_data
//
// One beat per cycle in and out unless either side stalls; an accepted beat goes through
// the two-entry command queue and the sequencer into the two-entry result queue.
// The sequencer advances one tick per beat; it waits on an empty command queue
// or a full result queue. Reset is synchronous, clears both queues and the sequencer
// and presets the opcodes; full rises once the command queue holds two beats.
module serial_register_access_master_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  srma_pkg::req_t req,
  output logic           empty,
  input  logic           pop,
  output srma_pkg::res_t res,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data
);

  srma_pkg::cmd_link_t head;
  logic                take;

  srma_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .req  (req),
    .take (take),
    .head (head)
  );

  srma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .take      (take),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

endmodule

// ===== rtl/core/srma_front.sv =====
// Front end: classifies request beats and holds them in a two-entry queue.
// Depends on srma_pkg.
module srma_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  srma_pkg::req_t    req,
  input  logic              take,
  output srma_pkg::cmd_link_t head
);

  srma_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  srma_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.item    = req;
    cmd_in.request = (req.mode >= srma_pkg::MODE_READ) && (req.mode <= srma_pkg::MODE_FREAD);
  end

  assign full       = count[1];
  assign do_push    = push && !full;
  assign do_pop     = take && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/core/srma_back.sv =====
// Back end: serial frame sequencer, opcode registers and a two-entry result queue.
// Depends on srma_pkg.
module srma_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  srma_pkg::cmd_link_t head,
  output logic                take,
  output logic                empty,
  input  logic                pop,
  output srma_pkg::res_t      res
);

  logic [7:0] read_opcode;
  logic [7:0] write_opcode;

  logic [2:0] phase, phase_next;
  logic [srma_pkg::CNT_W-1:0] half_bit_count, half_bit_count_next;
  logic [7:0] shifter, shifter_next;
  logic [7:0] captured_byte, captured_byte_next;
  logic [2:0] pending_op, pending_op_next;
  logic [4:0] held_addr, held_addr_next;
  logic [2:0] held_shift, held_shift_next;
  logic [7:0] held_mask, held_mask_next;
  logic [7:0] held_value, held_value_next;

  srma_pkg::res_t slots [2];
  srma_pkg::res_t res_in;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  logic [7:0] sh;
  logic [7:0] m_sh;
  logic [7:0] v_sh;
  logic [srma_pkg::CNT_W-1:0] cnt_inc;
  srma_pkg::req_t it;

  assign it      = head.cmd.item;
  assign take    = head.valid && !count[1];
  assign empty   = (count == 2'd0);
  assign do_pop  = pop && !empty;
  assign res     = slots[rd_ptr];
  assign sh      = {shifter[6:0], it.miso};
  assign m_sh    = held_mask << held_shift;
  assign v_sh    = (held_value & held_mask) << held_shift;
  assign cnt_inc = half_bit_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_opcode  <= 8'd32;
      write_opcode <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srma_pkg::CFG_READ_OP:  read_opcode  <= cfg_data;
        srma_pkg::CFG_WRITE_OP: write_opcode <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next          = phase;
    half_bit_count_next = half_bit_count;
    shifter_next        = shifter;
    captured_byte_next  = captured_byte;
    pending_op_next     = pending_op;
    held_addr_next      = held_addr;
    held_shift_next     = held_shift;
    held_mask_next      = held_mask;
    held_value_next     = held_value;
    res_in              = '0;

    if (phase == srma_pkg::PH_IDLE) begin
      if (head.cmd.request) begin
        pending_op_next     = it.mode;
        held_addr_next      = it.reg_addr;
        held_shift_next     = it.bit_shift;
        held_mask_next      = it.field_mask;
        held_value_next     = it.write_value;
        shifter_next        = ((it.mode == srma_pkg::MODE_WRITE) ? write_opcode : read_opcode)
                              | {3'b000, it.reg_addr & srma_pkg::ADDR_MASK};
        half_bit_count_next = '0;
        phase_next          = srma_pkg::PH_F1_OP;
        res_in.select       = 1'b1;
      end
    end else begin
      res_in.rejected = head.cmd.request;
      unique case (phase)
        srma_pkg::PH_GAP: begin
          shifter_next        = write_opcode | {3'b000, held_addr & srma_pkg::ADDR_MASK};
          half_bit_count_next = '0;
          phase_next          = srma_pkg::PH_F2_OP;
        end
        srma_pkg::PH_F1_OP, srma_pkg::PH_F1_DATA,
        srma_pkg::PH_F2_OP, srma_pkg::PH_F2_DATA: begin
          res_in.select = 1'b1;
          res_in.mosi   = (shifter & srma_pkg::MSB_MASK) != 8'd0;
          half_bit_count_next = cnt_inc;
          if (!half_bit_count[0]) begin
            res_in.clock_pin = 1'b1;
          end else begin
            shifter_next = sh;
            if (cnt_inc >= srma_pkg::CNT_W'(srma_pkg::HALF_BITS)) begin
              half_bit_count_next = '0;
              unique case (phase)
                srma_pkg::PH_F1_OP: begin
                  shifter_next = (pending_op == srma_pkg::MODE_WRITE) ? held_value : 8'd0;
                  phase_next   = srma_pkg::PH_F1_DATA;
                end
                srma_pkg::PH_F1_DATA: begin
                  captured_byte_next = sh;
                  if (pending_op == srma_pkg::MODE_MWRITE) begin
                    phase_next = srma_pkg::PH_GAP;
                  end else begin
                    res_in.done_res = 1'b1;
                    phase_next      = srma_pkg::PH_IDLE;
                    if (pending_op == srma_pkg::MODE_READ) begin
                      res_in.read_data = sh;
                    end else if (pending_op == srma_pkg::MODE_FREAD) begin
                      res_in.read_data = (sh >> held_shift) & held_mask;
                    end
                  end
                end
                srma_pkg::PH_F2_OP: begin
                  shifter_next = (captured_byte & ~m_sh) | v_sh;
                  phase_next   = srma_pkg::PH_F2_DATA;
                end
                default: begin
                  res_in.done_res = 1'b1;
                  phase_next      = srma_pkg::PH_IDLE;
                end
              endcase
            end
          end
        end
        default: begin
          phase_next = srma_pkg::PH_IDLE;
        end
      endcase
    end
    res_in.busy_res = (phase_next != srma_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= srma_pkg::PH_IDLE;
      half_bit_count <= '0;
      shifter        <= '0;
      captured_byte  <= '0;
      pending_op     <= '0;
      held_addr      <= '0;
      held_shift     <= '0;
      held_mask      <= '0;
      held_value     <= '0;
    end else if (take) begin
      phase          <= phase_next;
      half_bit_count <= half_bit_count_next;
      shifter        <= shifter_next;
      captured_byte  <= captured_byte_next;
      pending_op     <= pending_op_next;
      held_addr      <= held_addr_next;
      held_shift     <= held_shift_next;
      held_mask      <= held_mask_next;
      held_value     <= held_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slots[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (take) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, take} - {1'b0, do_pop};
    end
  end

endmodule

// ===== sim/tb_serial_register_access_master_unit.sv =====
// Testbench for serial_register_access_master_unit: drives request beats, predicts each
// result beat from a cycle-free model of the frame sequencer and checks them in order.
// Depends on srma_pkg and the RTL under rtl/core.
module tb_serial_register_access_master_unit;
  import srma_pkg::*;

  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          PHASE_BEATS   = 290;
  localparam logic [2:0]  MODE_SPARE_HI = 3'd7;

  logic       clk;
  logic       rst       = 1'b1;
  logic       push      = 1'b0;
  logic       pop       = 1'b0;
  logic       cfg_we    = 1'b0;
  logic       cfg_index = CFG_READ_OP;
  logic [7:0] cfg_data  = '0;
  req_t       req       = '0;
  logic       full;
  logic       empty;
  res_t       res;

  int   send_idle_pct = 0;
  int   pop_stall_pct = 0;
  int   fails         = 0;
  int   cycles        = 0;
  res_t expected_q[$];

  // sequencer model state
  logic [7:0] rd_opcode, wr_opcode;
  logic [2:0] seq_phase, cur_op, cur_shift;
  logic [4:0] tick_count, cur_addr;
  logic [7:0] out_shift, last_byte, cur_mask, cur_value;

  serial_register_access_master_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_serial_register_access_master_unit: FAIL");
      $finish;
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fails++;
        end else begin
          res_t want;
          want = expected_q.pop_front();
          check_field("select", want.select, res.select);
          check_field("clock_pin", want.clock_pin, res.clock_pin);
          check_field("mosi", want.mosi, res.mosi);
          check_field("busy_res", want.busy_res, res.busy_res);
          check_field("done_res", want.done_res, res.done_res);
          check_field("read_data", want.read_data, res.read_data);
          check_field("rejected", want.rejected, res.rejected);
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  function automatic void reset_model();
    rd_opcode  = 8'd32;
    wr_opcode  = 8'd0;
    seq_phase  = PH_IDLE;
    tick_count = '0;
    out_shift  = '0;
    last_byte  = '0;
    cur_op     = '0;
    cur_addr   = '0;
    cur_shift  = '0;
    cur_mask   = '0;
    cur_value  = '0;
  endfunction

  function automatic res_t predict_beat(req_t b);
    res_t       r;
    logic       request;
    logic [7:0] field_bits, field_val;
    r = '0;
    request = (b.mode >= MODE_READ) && (b.mode <= MODE_FREAD);
    if (seq_phase == PH_IDLE) begin
      if (request) begin
        cur_op     = b.mode;
        cur_addr   = b.reg_addr;
        cur_shift  = b.bit_shift;
        cur_mask   = b.field_mask;
        cur_value  = b.write_value;
        out_shift  = ((cur_op == MODE_WRITE) ? wr_opcode : rd_opcode) | {3'b000, cur_addr};
        tick_count = '0;
        seq_phase  = PH_F1_OP;
        r.select   = 1'b1;
      end
    end else begin
      r.rejected = request;
      if (seq_phase == PH_GAP) begin
        out_shift  = wr_opcode | {3'b000, cur_addr & ADDR_MASK};
        tick_count = '0;
        seq_phase  = PH_F2_OP;
      end else if (seq_phase == PH_F1_OP || seq_phase == PH_F1_DATA ||
                   seq_phase == PH_F2_OP || seq_phase == PH_F2_DATA) begin
        r.select = 1'b1;
        r.mosi   = (out_shift & MSB_MASK) != 0;
        if (!tick_count[0]) begin
          r.clock_pin = 1'b1;
          tick_count  = tick_count + 1'b1;
        end else begin
          out_shift  = {out_shift[6:0], b.miso};
          tick_count = tick_count + 1'b1;
          if (tick_count >= HALF_BITS) begin
            tick_count = '0;
            case (seq_phase)
              PH_F1_OP: begin
                out_shift = (cur_op == MODE_WRITE) ? cur_value : 8'h00;
                seq_phase = PH_F1_DATA;
              end
              PH_F1_DATA: begin
                last_byte = out_shift;
                if (cur_op == MODE_MWRITE) begin
                  seq_phase = PH_GAP;
                end else begin
                  r.done_res = 1'b1;
                  seq_phase  = PH_IDLE;
                  if (cur_op == MODE_READ) r.read_data = last_byte;
                  else if (cur_op == MODE_FREAD)
                    r.read_data = (last_byte >> cur_shift) & cur_mask;
                end
              end
              PH_F2_OP: begin
                field_bits = cur_mask << cur_shift;
                field_val  = (cur_value & cur_mask) << cur_shift;
                out_shift  = (last_byte & ~field_bits) | field_val;
                seq_phase  = PH_F2_DATA;
              end
              default: begin
                r.done_res = 1'b1;
                seq_phase  = PH_IDLE;
              end
            endcase
          end
        end
      end else begin
        seq_phase = PH_IDLE;
      end
    end
    r.busy_res = (seq_phase != PH_IDLE);
    return r;
  endfunction

  // last: drop push once this beat leaves the sequencer idle
  task automatic send_beat(input req_t b, input bit last);
    res_t want;
    want = predict_beat(b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req  <= b;
    do @(posedge clk); while (full);
    expected_q.push_back(want);
    if (last && seq_phase == PH_IDLE) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic req_t make_req(logic [2:0] mode, logic [4:0] addr, logic [2:0] sh,
                                    logic [7:0] mask, logic [7:0] value);
    req_t b;
    b.mode        = mode;
    b.reg_addr    = addr;
    b.bit_shift   = sh;
    b.field_mask  = mask;
    b.write_value = value;
    b.miso        = 1'b0;
    return b;
  endfunction

  function automatic logic [2:0] rand_request_mode();
    return 3'($urandom_range(MODE_READ, MODE_FREAD));
  endfunction

  function automatic req_t rand_beat();
    req_t b;
    int   pick;
    b    = req_t'(28'($urandom));
    pick = $urandom_range(99);
    if (seq_phase == PH_IDLE) begin
      if (pick < 85) b.mode = rand_request_mode();
      else if (pick < 93) b.mode = MODE_TICK;
      else b.mode = 3'($urandom_range(MODE_FREAD + 1, MODE_SPARE_HI));
    end else begin
      if (pick < 6) b.mode = rand_request_mode();
      else if (pick < 96) b.mode = MODE_TICK;
      else b.mode = 3'($urandom_range(MODE_FREAD + 1, MODE_SPARE_HI));
    end
    return b;
  endfunction

  // miso_kind: 0 holds miso low, 1 holds it high, 2 randomizes it
  task automatic end_burst(input int miso_kind, input bit poke);
    req_t t;
    int   n;
    n = 0;
    do begin
      t      = req_t'(28'($urandom));
      t.mode = MODE_TICK;
      if (miso_kind == 0) t.miso = 1'b0;
      else if (miso_kind == 1) t.miso = 1'b1;
      if (poke && n == 5) t.mode = rand_request_mode();
      send_beat(t, 1'b1);
      n++;
    end while (seq_phase != PH_IDLE);
  endtask

  task automatic run_op(input req_t rq, input int miso_kind, input bit poke);
    send_beat(rq, 1'b0);
    end_burst(miso_kind, poke);
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] value);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_READ_OP) rd_opcode = value;
    else wr_opcode = value;
  endtask

  task automatic test_idle_ticks();
    req_t b;
    for (int i = 0; i < 4; i++) begin
      b      = req_t'(28'($urandom));
      b.mode = (i == 0) ? MODE_TICK : 3'(MODE_FREAD + i);
      b.miso = 1'b1;
      send_beat(b, i == 3);
    end
  endtask

  task automatic test_read();
    run_op(make_req(MODE_READ, 5'd0, 3'd0, 8'h00, 8'h00), 1, 1'b0);
    run_op(make_req(MODE_READ, 5'd31, 3'd7, 8'hff, 8'hff), 0, 1'b0);
    run_op(make_req(MODE_READ, 5'($urandom), 3'd2, 8'h5a, 8'ha5), 2, 1'b1);
  endtask

  task automatic test_write();
    run_op(make_req(MODE_WRITE, 5'd31, 3'd0, 8'h00, 8'hff), 2, 1'b0);
    run_op(make_req(MODE_WRITE, 5'd0, 3'd7, 8'hff, 8'h00), 1, 1'b1);
  endtask

  task automatic test_masked_write();
    run_op(make_req(MODE_MWRITE, 5'd5, 3'd0, 8'hff, 8'ha5), 1, 1'b0);
    run_op(make_req(MODE_MWRITE, 5'd31, 3'd7, 8'hff, 8'hff), 0, 1'b1);
    run_op(make_req(MODE_MWRITE, 5'd10, 3'd3, 8'h0f, 8'hff), 2, 1'b0);
    run_op(make_req(MODE_MWRITE, 5'd0, 3'd4, 8'h00, 8'hff), 1, 1'b0);
  endtask

  task automatic test_field_read();
    run_op(make_req(MODE_FREAD, 5'd31, 3'd7, 8'hff, 8'h00), 1, 1'b0);
    run_op(make_req(MODE_FREAD, 5'd0, 3'd0, 8'h00, 8'hff), 1, 1'b0);
    run_op(make_req(MODE_FREAD, 5'd17, 3'd3, 8'h0f, 8'h3c), 2, 1'b1);
  endtask

  task automatic test_opcodes();
    cfg_write(CFG_READ_OP, 8'hff);
    cfg_write(CFG_WRITE_OP, 8'hff);
    run_op(make_req(MODE_READ, 5'd1, 3'd0, 8'h00, 8'h00), 2, 1'b0);
    run_op(make_req(MODE_MWRITE, 5'd2, 3'd1, 8'h03, 8'h02), 2, 1'b0);
    cfg_write(CFG_READ_OP, 8'h00);
    cfg_write(CFG_WRITE_OP, 8'h00);
    run_op(make_req(MODE_FREAD, 5'd30, 3'd5, 8'h07, 8'h00), 2, 1'b0);
    run_op(make_req(MODE_WRITE, 5'd12, 3'd0, 8'h00, 8'h81), 2, 1'b0);
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct,
                             input logic [7:0] rd_op, input logic [7:0] wr_op);
    cfg_write(CFG_READ_OP, rd_op);
    cfg_write(CFG_WRITE_OP, wr_op);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    for (int i = 0; i < PHASE_BEATS; i++) send_beat(rand_beat(), 1'b0);
    end_burst(2, 1'b0);
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_idle_ticks();
    test_read();
    test_write();
    test_masked_write();
    test_field_read();
    test_opcodes();
    test_random(0, 0, 8'h00, 8'hff);
    test_random(62, 0, 8'hff, 8'h00);
    test_random(0, 62, 8'($urandom), 8'($urandom));
    test_random(21, 21, 8'($urandom), 8'($urandom));
    wait_drain();
    if (fails == 0) begin
      $display("tb_serial_register_access_master_unit: PASS");
    end else begin
      $display("tb_serial_register_access_master_unit: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/srma_pkg.sv
rtl/core/srma_front.sv
rtl/core/srma_back.sv
rtl/core/serial_register_access_master_unit.sv
sim/tb_serial_register_access_master_unit.sv
